// ===== hw/rtl/signed_const_divider_core_assert.svh =====
// assertion macros shared by the divider modules
`ifndef SIGNED_CONST_DIVIDER_CORE_ASSERT_SVH
`define SIGNED_CONST_DIVIDER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SDC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sdc check failed");
// next-cycle implication
`define SDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sdc check failed");
// invariant on every cycle
`define SDC_ASSERT_HOLD(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("sdc check failed");
`else
`define SDC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define SDC_ASSERT_HOLD(lbl, clk, rstn, cond)
`endif
`endif

// ===== hw/rtl/sdc_pkg.sv =====
package sdc_pkg;

  // width of the fields on the ports
  localparam int DATA_W    = 32;
  // default internal datapath width
  localparam int WIDTH_DEF = 32;

  // classification of the held divisor
  typedef struct packed {
    logic zero;
    logic one;
    logic mone;
    logic pow2;
    logic neg;
  } div_kind_t;

endpackage

// ===== hw/rtl/sdc_intf.sv =====
// dividend channel
interface sdc_in_if;
  import sdc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] dividend;

  modport source (output valid, output dividend, input ready);
  modport sink   (input valid, input dividend, output ready);
endinterface

// quotient channel
interface sdc_out_if;
  import sdc_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] quotient;
  logic                     divisor_zero;

  modport source (output valid, output quotient, output divisor_zero, input ready);
  modport sink   (input valid, input quotient, input divisor_zero, output ready);
endinterface

// ===== hw/rtl/sdc_derive.sv =====
`include "signed_const_divider_core_assert.svh"

module sdc_derive import sdc_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [WIDTH-1:0]             cfg_div,
  output div_kind_t                    kind,
  output logic signed [WIDTH-1:0]      magic,
  output logic [$clog2(WIDTH+1)-1:0]   log_c,
  output logic [$clog2(WIDTH+1)-1:0]   shm1,
  output logic [WIDTH-1:0]             lmask,
  output logic                         busy
);

  localparam int LW = $clog2(WIDTH+1);
  localparam int CW = $clog2(2*WIDTH);

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_LOG, ST_DIV} state_t;

  state_t          state_r, state_nxt;
  div_kind_t       kind_r, kind_nxt;
  logic [WIDTH-1:0] mag_r, mag_nxt;
  logic [WIDTH-1:0] t_r, t_nxt;
  logic [LW-1:0]   l_r, l_nxt;
  logic [LW-1:0]   sh_r, sh_nxt;
  logic [WIDTH-1:0] lmask_r, lmask_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] magic_r, magic_nxt;

  logic [LW-1:0]   l_fin;
  logic [CW-1:0]   num_pos;
  logic            num_bit;
  logic [WIDTH:0]  trial;
  logic            q_bit;
  logic [WIDTH-1:0] quo_shift;
  logic [3:0]      kind_vec;

  // clamped log, bit position of the numerator's single one, trial subtract
  always_comb begin
    l_fin     = (l_r == '0) ? LW'(1) : l_r;
    num_pos   = CW'(WIDTH - 1) + CW'(l_r);
    num_bit   = (cnt_r == num_pos);
    trial     = {rem_r, num_bit};
    q_bit     = (trial >= {1'b0, mag_r});
    quo_shift = {quo_r[WIDTH-2:0], q_bit};
  end

  // sequencer: capture, log2 ceiling by shifting, then restoring division
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    mag_nxt   = mag_r;
    t_nxt     = t_r;
    l_nxt     = l_r;
    sh_nxt    = sh_r;
    lmask_nxt = lmask_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    magic_nxt = magic_r;
    case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          kind_nxt.zero = (cfg_div == '0);
          kind_nxt.one  = (cfg_div == WIDTH'(1));
          kind_nxt.mone = &cfg_div;
          kind_nxt.pow2 = 1'b0;
          kind_nxt.neg  = cfg_div[WIDTH-1];
          mag_nxt       = cfg_div[WIDTH-1] ? (~cfg_div + WIDTH'(1)) : cfg_div;
          state_nxt     = (cfg_div == '0) ? ST_IDLE : ST_PREP;
        end
      end
      ST_PREP: begin
        t_nxt         = mag_r - WIDTH'(1);
        l_nxt         = '0;
        kind_nxt.pow2 = ((mag_r & (mag_r - WIDTH'(1))) == '0) && (mag_r != WIDTH'(1));
        state_nxt     = ST_LOG;
      end
      ST_LOG: begin
        if (t_r != '0) begin
          l_nxt = l_r + LW'(1);
          t_nxt = t_r >> 1;
        end else begin
          l_nxt     = l_fin;
          sh_nxt    = l_fin - LW'(1);
          lmask_nxt = ~({WIDTH{1'b1}} << l_fin);
          cnt_nxt   = CW'(2*WIDTH - 1);
          rem_nxt   = '0;
          quo_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? WIDTH'(trial - {1'b0, mag_r}) : trial[WIDTH-1:0];
        quo_nxt = quo_shift;
        if (cnt_r == '0) begin
          magic_nxt = quo_shift + WIDTH'(1);
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and derived values; reset holds the values for divisor one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= '{zero: 1'b0, one: 1'b1, mone: 1'b0, pow2: 1'b0, neg: 1'b0};
      mag_r   <= WIDTH'(1);
      t_r     <= '0;
      l_r     <= LW'(1);
      sh_r    <= '0;
      lmask_r <= WIDTH'(1);
      cnt_r   <= '0;
      rem_r   <= '0;
      quo_r   <= '0;
      magic_r <= WIDTH'(1);
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      mag_r   <= mag_nxt;
      t_r     <= t_nxt;
      l_r     <= l_nxt;
      sh_r    <= sh_nxt;
      lmask_r <= lmask_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      quo_r   <= quo_nxt;
      magic_r <= magic_nxt;
    end
  end

  assign kind     = kind_r;
  assign magic    = magic_r;
  assign log_c    = l_r;
  assign shm1     = sh_r;
  assign lmask    = lmask_r;
  assign busy     = (state_r != ST_IDLE);
  assign kind_vec = {kind_r.zero, kind_r.one, kind_r.mone, kind_r.pow2};

  // checks
  `SDC_ASSERT_NEXT(a_cfg_start, clk, rst_n, state_r == ST_IDLE && cfg_we && cfg_div != '0, busy)
  `SDC_ASSERT_NOW(a_rem_bound, clk, rst_n, state_r == ST_DIV, rem_r < mag_r)
  `SDC_ASSERT_HOLD(a_kind_excl, clk, rst_n, $onehot0(kind_vec))

endmodule

// ===== hw/rtl/sdc_pipe.sv =====
`include "signed_const_divider_core_assert.svh"

module sdc_pipe import sdc_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  div_kind_t                   kind,
  input  logic signed [WIDTH-1:0]     magic,
  input  logic [$clog2(WIDTH+1)-1:0]  log_c,
  input  logic [$clog2(WIDTH+1)-1:0]  shm1,
  input  logic [WIDTH-1:0]            lmask,
  input  logic                        hold,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [WIDTH-1:0]     in_n,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WIDTH-1:0]     out_q,
  output logic                        out_dz
);

  localparam int LW = $clog2(WIDTH+1);

  // stage valids
  logic a_v_r, b_v_r, c_v_r, out_v_r;
  logic a_ready, b_ready, c_ready, d_ready;
  logic in_acc;

  // stage payloads
  logic signed [WIDTH-1:0]   a_n_r;
  logic signed [WIDTH-1:0]   b_n_r;
  logic signed [2*WIDTH-1:0] b_prod_r, b_prod_nxt;
  logic signed [WIDTH:0]     b_psum_r, b_psum_nxt;
  logic signed [WIDTH:0]     c_op_r, c_op_nxt;
  logic [LW-1:0]             c_amt_r, c_amt_nxt;
  logic                      c_inc_r, c_inc_nxt;
  logic signed [WIDTH-1:0]   out_q_r, out_q_nxt;
  logic                      out_dz_r, out_dz_nxt;

  logic                      gen;
  logic signed [WIDTH-1:0]   hi;
  logic signed [WIDTH:0]     gsum;
  logic signed [WIDTH:0]     shifted;
  logic [WIDTH-1:0]          sh_lo;

  // elastic handshake, each stage moves when the next one frees up
  assign d_ready  = !out_v_r || out_ready;
  assign c_ready  = !c_v_r || d_ready;
  assign b_ready  = !b_v_r || c_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign in_ready = a_ready && !hold;
  assign in_acc   = in_valid && in_ready;

  assign gen = !(kind.zero || kind.one || kind.mone || kind.pow2);

  // stage b: multiply-high product and biased dividend for the shift path
  always_comb begin
    b_prod_nxt = a_n_r * magic;
    b_psum_nxt = {a_n_r[WIDTH-1], a_n_r} + (a_n_r[WIDTH-1] ? {1'b0, lmask} : '0);
  end

  // stage c: pick the shift operand, amount and rounding increment
  always_comb begin
    hi   = b_prod_r[2*WIDTH-1:WIDTH];
    gsum = {b_n_r[WIDTH-1], b_n_r} + {hi[WIDTH-1], hi};
    if (kind.pow2) begin
      c_op_nxt  = b_psum_r;
      c_amt_nxt = log_c;
    end else if (gen) begin
      c_op_nxt  = gsum;
      c_amt_nxt = shm1;
    end else begin
      c_op_nxt  = {b_n_r[WIDTH-1], b_n_r};
      c_amt_nxt = '0;
    end
    c_inc_nxt = gen && b_n_r[WIDTH-1];
  end

  // stage d: arithmetic shift, then add increment or negate in one adder
  always_comb begin
    shifted = c_op_r >>> c_amt_r;
    sh_lo   = shifted[WIDTH-1:0];
    if (kind.zero) begin
      out_q_nxt  = '0;
      out_dz_nxt = 1'b1;
    end else begin
      out_q_nxt  = kind.neg ? (~sh_lo + WIDTH'(!c_inc_r)) : (sh_lo + WIDTH'(c_inc_r));
      out_dz_nxt = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (a_ready) a_v_r <= in_acc;
      if (b_ready) b_v_r <= a_v_r;
      if (c_ready) c_v_r <= b_v_r;
      if (d_ready) out_v_r <= c_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_n_r <= in_n;
    end
    if (a_v_r && b_ready) begin
      b_n_r    <= a_n_r;
      b_prod_r <= b_prod_nxt;
      b_psum_r <= b_psum_nxt;
    end
    if (b_v_r && c_ready) begin
      c_op_r  <= c_op_nxt;
      c_amt_r <= c_amt_nxt;
      c_inc_r <= c_inc_nxt;
    end
    if (c_v_r && d_ready) begin
      out_q_r  <= out_q_nxt;
      out_dz_r <= out_dz_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_q     = out_q_r;
  assign out_dz    = out_dz_r;

  // checks
  `SDC_ASSERT_NEXT(a_enter, clk, rst_n, in_acc, a_v_r)
  `SDC_ASSERT_NEXT(a_c_hold, clk, rst_n, c_v_r && !d_ready, c_v_r && $stable(c_op_r))
  `SDC_ASSERT_NOW(a_out_src, clk, rst_n, $rose(out_v_r), $past(c_v_r))

endmodule

// ===== hw/rtl/signed_const_divider_core.sv =====
// channel   dir  payload                      handshake
// in_if     in   dividend[31:0] signed         valid/ready
// out_if    out  quotient[31:0], divisor_zero  valid/ready
// cfg_*     in   cfg_wdata[31:0] divisor       cfg_we, no wait
//
// one dividend word per cycle unless stalled by out_if backpressure or by a
// divisor write; four register stages (input, multiply, correction add,
// shift/negate); a divisor write holds in_if.ready low while the log ceiling
// and magic multiplier are formed one bit per cycle
// reset gives divisor one; backpressure stalls full stages, bubbles still fill
module signed_const_divider_core import sdc_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  sdc_in_if.sink            in_if,
  sdc_out_if.source         out_if,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata
);

  localparam int LW = $clog2(WIDTH+1);

  div_kind_t               kind;
  logic signed [WIDTH-1:0] magic;
  logic [LW-1:0]           log_c;
  logic [LW-1:0]           shm1;
  logic [WIDTH-1:0]        lmask;
  logic                    busy;
  logic signed [WIDTH-1:0] q;

  // divisor classification and magic multiplier
  sdc_derive #(.WIDTH(WIDTH)) u_derive (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_div (cfg_wdata[WIDTH-1:0]),
    .kind    (kind),
    .magic   (magic),
    .log_c   (log_c),
    .shm1    (shm1),
    .lmask   (lmask),
    .busy    (busy)
  );

  // per-word quotient pipeline
  sdc_pipe #(.WIDTH(WIDTH)) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .kind      (kind),
    .magic     (magic),
    .log_c     (log_c),
    .shm1      (shm1),
    .lmask     (lmask),
    .hold      (busy || cfg_we),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_n      (in_if.dividend[WIDTH-1:0]),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_q     (q),
    .out_dz    (out_if.divisor_zero)
  );

  // sign-extend the quotient to the port width
  assign out_if.quotient = DATA_W'(q);

endmodule

// ===== tb/sdc_quotient_checker.sv =====
`timescale 1ns / 1ps

// watches the dividend, quotient and divisor ports, predicts each quotient word
module sdc_quotient_checker import sdc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  sdc_in_if                 in_ch,
  sdc_out_if                out_ch,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [DATA_W-1:0] quotient;
    logic              divisor_zero;
  } quot_word_t;

  // held divisor and the values derived from it
  longint            div_val;
  logic [DATA_W-1:0] magic_m;
  int unsigned       log_ceil;

  quot_word_t quot_q[$];
  int         fails = 0;
  int         waiting = 0;

  assign fail_count = fails;
  assign pending    = waiting;

  // log ceiling and magic multiplier for a new divisor
  function automatic void load_divisor(input logic [DATA_W-1:0] raw);
    longint      mag;
    longint      t;
    longint      m;
    int unsigned l;
    div_val = longint'(signed'(raw));
    if (div_val == 0) begin
      magic_m  = '0;
      log_ceil = 0;
      return;
    end
    mag = (div_val < 0) ? -div_val : div_val;
    t   = mag - 1;
    l   = 0;
    while (t != 0) begin
      l++;
      t = t >> 1;
    end
    if (l < 1) l = 1;
    m        = 1 + ((longint'(1) << (31 + l)) / mag);
    magic_m  = m[DATA_W-1:0];
    log_ceil = l;
  endfunction

  // quotient truncated toward zero under the held divisor
  function automatic quot_word_t quotient_of(input logic [DATA_W-1:0] raw);
    quot_word_t r;
    longint     n;
    longint     q;
    longint     x;
    longint     y;
    longint     mag;
    longint     mp;
    longint     hi;
    n = longint'(signed'(raw));
    r.divisor_zero = 1'b0;
    if (div_val == 0) begin
      r.quotient     = '0;
      r.divisor_zero = 1'b1;
      return r;
    end
    mag = (div_val < 0) ? -div_val : div_val;
    if (div_val == 1) begin
      q = n;
    end else if (div_val == -1) begin
      q = -n;
    end else if (log_ceil >= 1 && log_ceil < 32 && mag == (longint'(1) << log_ceil)) begin
      // power of two: bias negative dividends before the shift
      x = n >>> (log_ceil - 1);
      y = (x & 64'h0000_0000_FFFF_FFFF) >> (32 - log_ceil);
      q = (n + y) >>> log_ceil;
      if (div_val < 0) q = -q;
    end else begin
      // multiply-high, add back, shift, sign fix
      mp = longint'(signed'(magic_m));
      hi = (mp * n) >>> 32;
      q  = ((n + hi) >>> (log_ceil - 1)) + ((n < 0) ? 1 : 0);
      if (div_val < 0) q = -q;
    end
    r.quotient = q[DATA_W-1:0];
    return r;
  endfunction

  // predict on dividend accept, compare on quotient accept
  always @(posedge clk) begin
    quot_word_t want;
    if (!rst_n) begin
      load_divisor(32'd1);
      quot_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) quot_q.push_back(quotient_of(in_ch.dividend));
      if (out_ch.valid && out_ch.ready) begin
        if (quot_q.size() == 0) begin
          $display("%0t: unexpected word quotient %h divisor_zero %b", $time,
                   out_ch.quotient, out_ch.divisor_zero);
          fails++;
        end else begin
          want = quot_q.pop_front();
          if (out_ch.quotient !== want.quotient) begin
            $display("%0t: quotient expected %h actual %h", $time, want.quotient,
                     out_ch.quotient);
            fails++;
          end
          if (out_ch.divisor_zero !== want.divisor_zero) begin
            $display("%0t: divisor_zero expected %b actual %b", $time, want.divisor_zero,
                     out_ch.divisor_zero);
            fails++;
          end
        end
      end
      if (cfg_we) load_divisor(cfg_wdata);
    end
    waiting = quot_q.size();
  end

endmodule

// ===== tb/tb_signed_const_divider_core.sv =====
`timescale 1ns / 1ps

module tb_signed_const_divider_core;
  import sdc_pkg::*;

  localparam int     RAND_PHASES  = 26;
  localparam int     PHASE_WORDS  = 50;
  localparam int     DRAIN_CYCLES = 12;
  localparam longint CYCLE_LIMIT  = 200000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [DATA_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  bit                no_idle;
  longint            cycles = 0;

  sdc_in_if  in_ch ();
  sdc_out_if out_ch ();

  signed_const_divider_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sdc_quotient_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // quotient sink with random stalls
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready && rst_n));
    end
  end

  // one dividend word after a random gap
  task automatic send_word(input logic [DATA_W-1:0] v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop sending and wait for every quotient
  task automatic drain_quotients();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_divisor(input logic [DATA_W-1:0] v);
    drain_quotients();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_divisor();
    logic [DATA_W-1:0] ext [9];
    logic [DATA_W-1:0] v;
    int                s;
    ext = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
            32'd2, 32'hFFFF_FFFE, 32'd3, 32'hFFFF_FFFD};
    case ($urandom_range(0, 5))
      0: v = ext[$urandom_range(0, 8)];
      1: begin
        v = 32'd1 << $urandom_range(1, 31);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      2: begin
        s = $urandom_range(2, 1000);
        v = ($urandom_range(0, 1) != 0) ? -s : s;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] rand_dividend(input logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] ext [6];
    logic [DATA_W-1:0] v;
    int                k;
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0001};
    case ($urandom_range(0, 9))
      5: v = $urandom_range(0, 2000) - 1000;
      6: v = ext[$urandom_range(0, 5)];
      7, 8: begin
        // near a multiple of the divisor, where truncation flips
        k = int'($urandom()) >>> $urandom_range(0, 31);
        v = k * int'(d) + $urandom_range(0, 2) - 1;
      end
      9: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // stimulus and verdict
  initial begin
    logic [DATA_W-1:0] corner_n [5];
    logic [DATA_W-1:0] corner_d [5];
    logic [DATA_W-1:0] fixed_d [6];
    logic [DATA_W-1:0] d;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.dividend = '0;
    no_idle        = 1'b0;
    corner_n = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1};
    corner_d = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFF8, 32'd7};
    fixed_d  = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'h4000_0000, 32'd2, 32'hFFFF_FFFD};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: divisor one from reset, minus one, zero, negative power of two, general
    foreach (corner_d[j]) begin
      if (j != 0) write_divisor(corner_d[j]);
      foreach (corner_n[i]) send_word(corner_n[i]);
    end

    // random phases, each under its own divisor
    for (int p = 0; p < RAND_PHASES; p++) begin
      d = (p < 6) ? fixed_d[p] : rand_divisor();
      write_divisor(d);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 8 && i == PHASE_WORDS / 2) drain_quotients();
        send_word(rand_dividend(d));
      end
    end

    drain_quotients();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
